/* design/tepa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tepa_pkg
// Types and codes shared by the two-ended pipe ID allocator modules.
// ----------------------------------------------------------------------------
package tepa_pkg;

	localparam int HANDLE_W = 4;
	localparam int PIPE_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 3;

	typedef enum logic [1:0] {
		FUNC_ALLOC_FB   = 2'd0,
		FUNC_ALLOC_NORM = 2'd1,
		FUNC_FREE       = 2'd2,
		FUNC_NOP        = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK         = 3'd0,
		STS_NO_FREE    = 3'd1,
		STS_NOT_CONTIG = 3'd2,
		STS_RANGE      = 3'd3,
		STS_NOT_OWNED  = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]          func;
		logic [HANDLE_W-1:0] handle_id;
		logic [PIPE_W-1:0]   pipe_id;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PIPE_W-1:0]   granted_id;
		logic [COUNT_W-1:0]  fallback_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic check;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		func_t func;
		logic  hit;
		logic  last_chunk;
		logic  out_free;
	} dp_sts_t;

endpackage : tepa_pkg
`default_nettype wire

/* design/tepa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tepa_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module tepa_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : tepa_ram
`default_nettype wire

/* design/tepa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tepa_ctrl
// Request sequencer: accept, bitmap scan (allocation) or owner read (free),
// none for a no-op, then commit/respond.
module tepa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire tepa_pkg::dp_sts_t sts,
	output tepa_pkg::dp_cmd_t      cmd
);

	import tepa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (sts.func)
						FUNC_ALLOC_FB, FUNC_ALLOC_NORM: state_nxt = ST_SCAN;
						FUNC_FREE:                      state_nxt = ST_READ;
						default:                        state_nxt = ST_FINISH;
					endcase
				end
			end
			ST_SCAN: begin
				if (sts.hit || sts.last_chunk) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_READ: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_READ:   cmd.check  = 1'b1;
			ST_FINISH: cmd.commit = sts.out_free;
			default: ;
		endcase
	end

endmodule : tepa_ctrl
`default_nettype wire

/* design/tepa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tepa_dp
// Used-bit map, chunked free-ID search, owner table, fallback count and the
// response register.
// ----------------------------------------------------------------------------
module tepa_dp #(
	parameter int NUM_PIPES   = 64,
	parameter int NUM_HANDLES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tepa_pkg::req_t    in_req,
	input  wire tepa_pkg::dp_cmd_t cmd,
	output tepa_pkg::dp_sts_t      sts,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output tepa_pkg::rsp_t         out_rsp
);

	import tepa_pkg::*;

	localparam int IDW  = $clog2(NUM_PIPES);
	localparam int CNTW = $clog2(NUM_PIPES + 1);
	localparam int CW   = (NUM_PIPES >= 32) ? 32 : 8;
	localparam int CWB  = $clog2(CW);
	localparam int NCH  = (NUM_PIPES + CW - 1) / CW;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PADW = NCH * CW - NUM_PIPES;

	// handle modulo the handle count, a few compare-subtract steps
	function automatic logic [HANDLE_W-1:0] hmod(input logic [HANDLE_W-1:0] h);
		logic [8:0] v;
		v = 9'(h);
		for (int i = 0; i < 8; i++) begin
			if (v >= 9'(NUM_HANDLES)) begin
				v = v - 9'(NUM_HANDLES);
			end
		end
		return v[HANDLE_W-1:0];
	endfunction

	// request registers
	func_t               func_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [PIPE_W-1:0]   pid_q;

	// state
	logic [NUM_PIPES-1:0] used_q;
	logic [CNTW-1:0]      count_q;
	logic [CNTW-1:0]      count_nxt;

	// decision registers
	status_t        status_q;
	logic [IDW-1:0] gid_q;
	logic           do_alloc_q;
	logic           do_free_q;
	logic [CHW-1:0] chunk_q;

	logic              out_valid_q;
	rsp_t              rsp_q;
	logic              out_free;

	// search over one chunk
	logic [NCH-1:0][CW-1:0] map_pad;
	logic [CW-1:0]          free_bits;
	logic [CWB-1:0]         enc_lo;
	logic [CWB-1:0]         enc_hi;
	logic [CWB-1:0]         enc;
	logic [CHW+CWB-1:0]     id_wide;
	logic [IDW-1:0]         hit_id;
	logic                   is_fb;
	logic                   hit;
	logic                   last_chunk;

	logic [IDW-1:0]      pid_idx;
	logic [HANDLE_W-1:0] owner_rd;
	logic                owner_we;

	generate
		if (PADW > 0) begin : g_pad
			assign map_pad = {{PADW{1'b1}}, used_q};
		end else begin : g_nopad
			assign map_pad = used_q;
		end
	endgenerate

	assign free_bits = ~map_pad[chunk_q];
	assign hit       = |free_bits;
	assign is_fb     = (func_q == FUNC_ALLOC_FB);

	always_comb begin
		enc_lo = '0;
		for (int i = CW - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				enc_lo = CWB'(i);
			end
		end
	end

	always_comb begin
		enc_hi = '0;
		for (int i = 0; i < CW; i++) begin
			if (free_bits[i]) begin
				enc_hi = CWB'(i);
			end
		end
	end

	assign enc        = is_fb ? enc_lo : enc_hi;
	assign id_wide    = {chunk_q, enc};
	assign hit_id     = id_wide[IDW-1:0];
	assign last_chunk = is_fb ? (chunk_q == CHW'(NCH - 1)) : (chunk_q == '0);
	assign pid_idx    = pid_q[IDW-1:0];

	assign out_free = !out_valid_q || !out_stall;

	assign sts.func       = func_t'(in_req.func);
	assign sts.hit        = hit;
	assign sts.last_chunk = last_chunk;
	assign sts.out_free   = out_free;

	// request capture and scan pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func_t'(in_req.func);
			handle_q <= hmod(in_req.handle_id);
			pid_q    <= in_req.pipe_id;
			chunk_q  <= (func_t'(in_req.func) == FUNC_ALLOC_FB) ? '0 : CHW'(NCH - 1);
		end else if (cmd.scan && !hit) begin
			chunk_q <= is_fb ? chunk_q + 1'b1 : chunk_q - 1'b1;
		end
	end

	// decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q   <= STS_OK;
			gid_q      <= '0;
			do_alloc_q <= 1'b0;
			do_free_q  <= 1'b0;
		end else if (cmd.load) begin
			status_q   <= STS_OK;
			gid_q      <= '0;
			do_alloc_q <= 1'b0;
			do_free_q  <= 1'b0;
		end else if (cmd.scan) begin
			if (hit) begin
				if (is_fb && (CNTW'(hit_id) != count_q)) begin
					status_q <= STS_NOT_CONTIG;
				end else begin
					gid_q      <= hit_id;
					do_alloc_q <= 1'b1;
				end
			end else if (last_chunk) begin
				status_q <= STS_NO_FREE;
			end
		end else if (cmd.check) begin
			if ({1'b0, pid_q} >= COUNT_W'(NUM_PIPES)) begin
				status_q <= STS_RANGE;
			end else if (!used_q[pid_idx] || (owner_rd != handle_q)) begin
				status_q <= STS_NOT_OWNED;
			end else begin
				do_free_q <= 1'b1;
			end
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (do_alloc_q && is_fb) begin
			count_nxt = count_q + 1'b1;
		end else if (do_free_q && (COUNT_W'(pid_q) < COUNT_W'(count_q))) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// commit map and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
			if (do_alloc_q) begin
				used_q[gid_q] <= 1'b1;
			end else if (do_free_q) begin
				used_q[pid_idx] <= 1'b0;
			end
		end
	end

	assign owner_we = cmd.commit && do_alloc_q;

	tepa_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(NUM_PIPES)
	) u_owner_ram (
		.clk  (clk),
		.we   (owner_we),
		.waddr(gid_q),
		.wdata(handle_q),
		.re   (cmd.load),
		.raddr(in_req.pipe_id[IDW-1:0]),
		.rdata(owner_rd)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status         <= status_q;
			rsp_q.granted_id     <= do_alloc_q ? PIPE_W'(gid_q) : '0;
			rsp_q.fallback_count <= COUNT_W'(count_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = rsp_q;

endmodule : tepa_dp
`default_nettype wire

/* design/two_ended_pipe_id_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_ended_pipe_id_allocator_unit
// Pipe ID allocator: fallback IDs from the bottom, normal IDs from the top.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one response. A no-op request
// goes from accept straight to respond, a free goes through accept, owner
// table read and respond, and an allocation goes through accept, a scan of
// the used-bit map chunk by chunk (chunks of 32 IDs, 8 when NUM_PIPES < 32)
// until a free ID or the last chunk, and respond. The next request is taken
// while a response waits, but a stalled response holds that request in its
// respond state until the response is taken. The owner table needs no
// clearing after reset.
module two_ended_pipe_id_allocator_unit #(
	parameter int NUM_PIPES   = 64,
	parameter int NUM_HANDLES = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire tepa_pkg::req_t in_req,
	output logic                out_valid,
	input  wire logic           out_stall,
	output tepa_pkg::rsp_t      out_rsp
);

	import tepa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	tepa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	tepa_dp #(
		.NUM_PIPES  (NUM_PIPES),
		.NUM_HANDLES(NUM_HANDLES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_req   (in_req),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_rsp  (out_rsp)
	);

endmodule : two_ended_pipe_id_allocator_unit
`default_nettype wire
